// ----- sv/aesbc_pkg.sv -----
package aesbc_pkg;

	localparam int BlockW   = 128;
	localparam int KeyRegW  = 64;
	localparam int CfgIdxW  = 3;
	localparam int RkDepth  = 60;
	localparam int RkAddrW  = 6;
	localparam int RkRows   = 16;
	localparam int RkRowW   = 4;
	localparam int QueueDepth = 2;

	localparam logic [CfgIdxW-1:0] REG_MODE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd4;

	localparam logic [1:0] MODE_128 = 2'd0;
	localparam logic [1:0] MODE_192 = 2'd1;

	localparam logic ACT_ENC = 1'b0;

	typedef struct packed {
		logic              action;
		logic [BlockW-1:0] block;
	} req_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		logic [7:0] x;
		r = '0;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x;
			x = xtime(x);
		end
		gmul = r;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[x];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] x);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[x];
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		sub_word = {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
	endfunction

endpackage

// ----- sv/aesbc_req_if.sv -----
interface aesbc_req_if;
	logic         valid;
	logic         ready;
	logic         action;
	logic [63:0]  block_hi;
	logic [63:0]  block_lo;
	modport source (output valid, action, block_hi, block_lo, input ready);
	modport sink (input valid, action, block_hi, block_lo, output ready);
endinterface

// ----- sv/aesbc_res_if.sv -----
interface aesbc_res_if;
	logic         valid;
	logic         ready;
	logic [63:0]  result_hi;
	logic [63:0]  result_lo;
	modport source (output valid, result_hi, result_lo, input ready);
	modport sink (input valid, result_hi, result_lo, output ready);
endinterface

// ----- sv/aesbc_ram.sv -----
module aesbc_ram #(
	parameter int Width = 32,
	parameter int Depth = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- sv/aesbc_front.sv -----
module aesbc_front #(
	parameter int Depth = aesbc_pkg::QueueDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	aesbc_req_if.sink      req,
	output logic           q_valid,
	input  logic           q_pop,
	output aesbc_pkg::req_t q_head
);
	import aesbc_pkg::*;

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

	req_t              slot_q [Depth];
	logic [PtrW-1:0]   wr_q, rd_q;
	logic [PtrW:0]     cnt_q;
	logic              push;

	assign req.ready = (cnt_q != (PtrW+1)'(Depth));
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != '0);
	assign q_head    = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= '{action: req.action, block: {req.block_hi, req.block_lo}};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
		end
	end
endmodule

// ----- sv/aesbc_back.sv -----
module aesbc_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aesbc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [aesbc_pkg::KeyRegW-1:0] cfg_data,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  aesbc_pkg::req_t               q_head,
	aesbc_res_if.source                   res
);
	import aesbc_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_EXPAND = 4'b0010,
		ST_KEY0   = 4'b0100,
		ST_ROUND  = 4'b1000
	} state_t;

	state_t             state_q;
	logic [1:0]         mode_q;
	logic [63:0]        key_q [4];
	logic               sched_ok_q;
	logic [31:0]        win_q [8];
	logic [RkAddrW-1:0] wi_q;
	logic [3:0]         kidx_q;
	logic [7:0]         rcon_q;
	logic               act_q;
	logic [3:0]         rnd_q;
	logic [127:0]       st_q;
	logic               out_v_q;
	logic [127:0]       out_q;
	logic [3:0]         nk, nr, rnd_step;
	logic [RkAddrW-1:0] total;
	logic               cfg_hit, last, ram_we, expand_end;
	logic [31:0]        key_word, old_word, tmp, new_word;
	logic [RkRowW-1:0]  ram_raddr;
	logic [127:0]       rk, round_out;

	function automatic logic [127:0] fwd_round(input logic [127:0] s, input logic lst);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [127:0] o;
		for (int i = 0; i < 16; i++) b[i] = sbox(s[127-8*i -: 8]);
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) t[4*c+r] = b[4*((c+r)%4)+r];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127-8*(4*c+r) -: 8] = lst ? t[4*c+r] :
					(gmul(t[4*c+r], 8'd2) ^ gmul(t[4*c+(r+1)%4], 8'd3) ^
					 t[4*c+(r+2)%4] ^ t[4*c+(r+3)%4]);
		fwd_round = o;
	endfunction

	function automatic logic [127:0] inv_round(input logic [127:0] s,
		input logic [127:0] k, input logic lst);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [127:0] o;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) t[4*((c+r)%4)+r] = s[127-8*(4*c+r) -: 8];
		for (int i = 0; i < 16; i++) b[i] = inv_sbox(t[i]) ^ k[127-8*i -: 8];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				o[127-8*(4*c+r) -: 8] = lst ? b[4*c+r] :
					(gmul(b[4*c+r], 8'd14) ^ gmul(b[4*c+(r+1)%4], 8'd11) ^
					 gmul(b[4*c+(r+2)%4], 8'd13) ^ gmul(b[4*c+(r+3)%4], 8'd9));
		inv_round = o;
	endfunction

	assign nk      = (mode_q == MODE_128) ? 4'd4 : (mode_q == MODE_192) ? 4'd6 : 4'd8;
	assign nr      = nk + 4'd6;
	assign total   = {nk, 2'b00} + RkAddrW'(28);
	assign cfg_hit = cfg_we && (cfg_index <= REG_KEY3);
	assign expand_end = (state_q == ST_EXPAND) && (wi_q == total - 1'b1);

	// schedule word generator, window holds the last eight words
	always_comb begin
		key_word = wi_q[0] ? key_q[wi_q[2:1]][31:0] : key_q[wi_q[2:1]][63:32];
		old_word = (nk == 4'd4) ? win_q[4] : (nk == 4'd6) ? win_q[2] : win_q[0];
		tmp = win_q[7];
		if (kidx_q == 4'd0)
			tmp = sub_word({tmp[23:0], tmp[31:24]}) ^ {rcon_q, 24'h0};
		else if (nk == 4'd8 && kidx_q == 4'd4)
			tmp = sub_word(tmp);
		new_word = (wi_q < RkAddrW'(nk)) ? key_word : (old_word ^ tmp);
	end

	// one 128-bit row per round key
	assign ram_we    = (state_q == ST_EXPAND) && (wi_q[1:0] == 2'b11);
	assign rnd_step  = (act_q == ACT_ENC) ? rnd_q + 4'd1 : rnd_q - 4'd1;
	assign ram_raddr = (state_q == ST_IDLE) ? ((q_head.action == ACT_ENC) ? '0 : nr) : rnd_step;

	aesbc_ram #(.Width(BlockW), .Depth(RkRows)) u_rk (
		.clk(clk), .we(ram_we), .waddr(wi_q[RkAddrW-1:2]),
		.wdata({win_q[5], win_q[6], win_q[7], new_word}),
		.raddr(ram_raddr), .rdata(rk)
	);

	assign last      = (act_q == ACT_ENC) ? (rnd_q == nr) : (rnd_q == 4'd0);
	assign round_out = (act_q == ACT_ENC) ? (fwd_round(st_q, last) ^ rk) :
		inv_round(st_q, rk, last);

	assign q_pop = (state_q == ST_IDLE) && q_valid && sched_ok_q && !out_v_q;
	assign res.valid     = out_v_q;
	assign res.result_hi = out_q[127:64];
	assign res.result_lo = out_q[63:0];

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_EXPAND: begin
				for (int i = 0; i < 7; i++) win_q[i] <= win_q[i+1];
				win_q[7] <= new_word;
			end
			ST_IDLE: begin
				if (q_pop) st_q <= q_head.block;
			end
			ST_KEY0: st_q <= st_q ^ rk;
			ST_ROUND: begin
				st_q <= round_out;
				if (last) out_q <= round_out;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_128;
			for (int i = 0; i < 4; i++) key_q[i] <= '0;
			sched_ok_q <= 1'b0;
			out_v_q    <= 1'b0;
			wi_q       <= '0;
			kidx_q     <= 4'd0;
			rcon_q     <= 8'h01;
			act_q      <= ACT_ENC;
			rnd_q      <= 4'd0;
		end else begin
			if (cfg_we && cfg_index == REG_MODE) mode_q <= cfg_data[1:0];
			if (cfg_we && cfg_index >= REG_KEY0 && cfg_index <= REG_KEY3)
				key_q[2'(cfg_index - REG_KEY0)] <= cfg_data;
			if (cfg_hit) sched_ok_q <= 1'b0;
			else if (expand_end) sched_ok_q <= 1'b1;
			if (state_q == ST_ROUND && last) out_v_q <= 1'b1;
			else if (res.ready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && !sched_ok_q && !cfg_hit) begin
						wi_q    <= '0;
						kidx_q  <= 4'd0;
						rcon_q  <= 8'h01;
						state_q <= ST_EXPAND;
					end else if (q_pop) begin
						act_q   <= q_head.action;
						rnd_q   <= (q_head.action == ACT_ENC) ? 4'd0 : nr;
						state_q <= ST_KEY0;
					end
				end
				ST_EXPAND: begin
					if (wi_q >= RkAddrW'(nk) && kidx_q == 4'd0) rcon_q <= xtime(rcon_q);
					kidx_q <= (kidx_q == nk - 4'd1) ? 4'd0 : kidx_q + 4'd1;
					wi_q   <= wi_q + 1'b1;
					if (cfg_hit || expand_end) state_q <= ST_IDLE;
				end
				ST_KEY0: begin
					rnd_q   <= rnd_step;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_step;
					if (last) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- sv/aes_block_cipher_core.sv -----
// channel   dir  payload                       handshake
// req       in   action, block_hi, block_lo    valid/ready
// res       out  result_hi, result_lo          valid/ready
// cfg       in   cfg_index, cfg_data           cfg_we
// a block passes through the back end in order: start, initial key add, nr rounds at one per cycle
// round keys are 128-bit ram rows, each read in the cycle before its round
// after a key or mode write the next request first waits for the key expansion
// reset clears control state and key registers; a waiting result stalls the back end
module aes_block_cipher_core #(
	parameter int QDepth = aesbc_pkg::QueueDepth
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [aesbc_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [aesbc_pkg::KeyRegW-1:0] cfg_data,
	aesbc_req_if.sink                     req,
	aesbc_res_if.source                   res
);
	import aesbc_pkg::*;

	logic q_valid, q_pop;
	req_t q_head;

	aesbc_front #(.Depth(QDepth)) u_front (.clk(clk), .arst_n(arst_n), .req(req),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head));

	aesbc_back u_back (.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .q_valid(q_valid),
		.q_pop(q_pop), .q_head(q_head), .res(res));
endmodule

// ----- verif/tb.sv -----
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import aesbc_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_KEY1 = REG_KEY0 + 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KEY2 = REG_KEY0 + 3'd2;
	localparam logic [1:0] MODE_256 = MODE_192 + 2'd1;
	localparam logic ACT_DEC = ~ACT_ENC;
	localparam int SettleCycles = 200;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;

	aesbc_req_if req ();
	aesbc_res_if res ();

	aes_block_cipher_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.req(req.sink),
		.res(res.source)
	);

	logic [7:0] fwd_sb [256];
	logic [7:0] inv_sb [256];
	logic [1:0] mode_q;
	logic [63:0] key_q [4];
	logic [31:0] key_sched [RkDepth];
	logic [7:0] st [16];

	logic [127:0] pending_blocks [$];
	int errors;
	int blocks_sent;
	int blocks_checked;
	int hold_off;
	bit rx_fast;

	function automatic logic [7:0] gf_dbl(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] r;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ a;
			a = gf_dbl(a);
		end
		return r;
	endfunction

	function automatic logic [7:0] rotl8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	function automatic void build_sboxes();
		logic [7:0] inv;
		logic [7:0] s;
		for (int x = 0; x < 256; x++) begin
			inv = 8'h01;
			for (int k = 0; k < 254; k++) inv = gf_mul(inv, x[7:0]);
			if (x == 0) inv = 8'h00;
			s = inv ^ rotl8(inv, 1) ^ rotl8(inv, 2) ^ rotl8(inv, 3) ^ rotl8(inv, 4) ^ 8'h63;
			fwd_sb[x] = s;
			inv_sb[s] = x[7:0];
		end
	endfunction

	function automatic int key_len_words();
		return mode_q == MODE_128 ? 4 : (mode_q == MODE_192 ? 6 : 8);
	endfunction

	function automatic logic [31:0] sub_w(input logic [31:0] w);
		return {fwd_sb[w[31:24]], fwd_sb[w[23:16]], fwd_sb[w[15:8]], fwd_sb[w[7:0]]};
	endfunction

	function automatic void expand_keys();
		int nk;
		int total;
		logic [7:0] rcon;
		logic [31:0] t;
		nk = key_len_words();
		total = 4 * (nk + 7);
		rcon = 8'h01;
		for (int i = 0; i < nk; i++)
			key_sched[i] = i[0] ? key_q[(i >> 1) & 3][31:0] : key_q[(i >> 1) & 3][63:32];
		for (int i = nk; i < total && i < RkDepth; i++) begin
			t = key_sched[i-1];
			if (i % nk == 0) begin
				t = sub_w({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
				rcon = gf_dbl(rcon);
			end else if (nk > 6 && i % nk == 4) begin
				t = sub_w(t);
			end
			key_sched[i] = key_sched[i-nk] ^ t;
		end
	endfunction

	function automatic void add_rk(input int rnd);
		logic [31:0] w;
		for (int c = 0; c < 4; c++) begin
			w = key_sched[(rnd * 4 + c) % RkDepth];
			for (int r = 0; r < 4; r++) st[4*c+r] = st[4*c+r] ^ w[31-8*r -: 8];
		end
	endfunction

	function automatic void sub_st(input bit inverse);
		for (int i = 0; i < 16; i++) st[i] = inverse ? inv_sb[st[i]] : fwd_sb[st[i]];
	endfunction

	function automatic void shift_st(input bit inverse);
		logic [7:0] t [16];
		t = st;
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (inverse) st[4*((c+r)&3)+r] = t[4*c+r];
				else st[4*c+r] = t[4*((c+r)&3)+r];
			end
	endfunction

	function automatic void mix_st(input bit inverse);
		logic [7:0] m [4];
		logic [7:0] col [4];
		logic [7:0] acc;
		if (inverse) m = '{8'd14, 8'd11, 8'd13, 8'd9};
		else m = '{8'd2, 8'd3, 8'd1, 8'd1};
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) col[k] = st[4*c+k];
			for (int r = 0; r < 4; r++) begin
				acc = '0;
				for (int k = 0; k < 4; k++) acc = acc ^ gf_mul(m[(k+4-r)&3], col[k]);
				st[4*c+r] = acc;
			end
		end
	endfunction

	function automatic logic [127:0] cipher_block(input logic act, input logic [127:0] blk);
		int nr;
		logic [127:0] o;
		nr = key_len_words() + 6;
		for (int i = 0; i < 16; i++) st[i] = blk[127-8*i -: 8];
		if (act == ACT_ENC) begin
			add_rk(0);
			for (int r = 1; r < nr; r++) begin
				sub_st(0);
				shift_st(0);
				mix_st(0);
				add_rk(r);
			end
			sub_st(0);
			shift_st(0);
			add_rk(nr);
		end else begin
			add_rk(nr);
			for (int r = nr - 1; r > 0; r--) begin
				shift_st(1);
				sub_st(1);
				add_rk(r);
				mix_st(1);
			end
			shift_st(1);
			sub_st(1);
			add_rk(0);
		end
		for (int i = 0; i < 16; i++) o[127-8*i -: 8] = st[i];
		return o;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// result side: random stalls, long hold-off on request, checks each result
	initial begin
		int gap;
		logic [127:0] want;
		gap = 0;
		res.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (res.valid && res.ready) begin
				if (pending_blocks.size() == 0) begin
					report_mismatch("unexpected result_hi", res.result_hi, 64'h0);
				end else begin
					want = pending_blocks.pop_front();
					if (res.result_hi !== want[127:64])
						report_mismatch("result_hi", res.result_hi, want[127:64]);
					if (res.result_lo !== want[63:0])
						report_mismatch("result_lo", res.result_lo, want[63:0]);
					blocks_checked++;
				end
				gap = rx_fast ? 0 : $urandom_range(0, 7);
			end
			if (hold_off > 0) begin
				hold_off--;
				res.ready <= 1'b0;
			end else if (gap > 0) begin
				gap--;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	task automatic send_block(input logic act, input logic [63:0] hi, input logic [63:0] lo,
			input bit no_gap = 0);
		int gap;
		gap = no_gap ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.action <= act;
		req.block_hi <= hi;
		req.block_lo <= lo;
		do @(posedge clk); while (!req.ready);
		pending_blocks.push_back(cipher_block(act, {hi, lo}));
		blocks_sent++;
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (pending_blocks.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_MODE) mode_q = val[1:0];
		else if (idx <= REG_KEY3) key_q[2'(idx - REG_KEY0)] = val;
	endtask

	task automatic load_key(input logic [1:0] mode, input logic [63:0] k0, input logic [63:0] k1,
			input logic [63:0] k2, input logic [63:0] k3);
		drain();
		write_reg(REG_MODE, {62'h0, mode});
		write_reg(REG_KEY0, k0);
		write_reg(REG_KEY1, k1);
		write_reg(REG_KEY2, k2);
		write_reg(REG_KEY3, k3);
		cfg_we <= 1'b0;
		expand_keys();
		@(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic test_known_vectors();
		logic [63:0] k0;
		logic [63:0] k1;
		logic [63:0] k2;
		logic [63:0] k3;
		k0 = 64'h0001020304050607;
		k1 = 64'h08090a0b0c0d0e0f;
		k2 = 64'h1011121314151617;
		k3 = 64'h18191a1b1c1d1e1f;
		// reset key, schedule never expanded yet
		send_block(ACT_ENC, 64'h0, 64'h0);
		send_block(ACT_DEC, 64'h0, 64'h0);
		for (int m = 0; m < 4; m++) begin
			load_key(m[1:0], k0, k1, k2, k3);
			send_block(ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
			send_block(ACT_DEC, 64'h0011223344556677, 64'h8899aabbccddeeff);
			send_block(ACT_ENC, '1, '1);
			send_block(ACT_DEC, '0, '1);
		end
		// unused key words must not matter
		load_key(MODE_128, k0, k1, '1, '1);
		send_block(ACT_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
		load_key(MODE_192, '1, '1, '1, 64'h0);
		send_block(ACT_DEC, '1, '0);
	endtask

	task automatic test_bad_index();
		drain();
		for (int i = REG_KEY3 + 1; i < 8; i++) write_reg(i[2:0], rand64());
		cfg_we <= 1'b0;
		@(posedge clk);
		send_block(ACT_ENC, rand64(), rand64());
		send_block(ACT_DEC, rand64(), rand64());
	endtask

	task automatic test_backpressure();
		load_key(MODE_256, rand64(), rand64(), rand64(), rand64());
		hold_off = 400;
		for (int i = 0; i < 10; i++)
			send_block(1'($urandom_range(0, 1)), rand64(), rand64(), 1);
		drain();
	endtask

	task automatic test_random();
		logic [1:0] mode;
		int n;
		for (int ph = 0; ph < 9; ph++) begin
			mode = ph < 4 ? ph[1:0] : 2'($urandom_range(0, 3));
			rx_fast = (ph % 3 == 1);
			if (ph == 0) load_key(mode, '0, '0, '0, '0);
			else if (ph == 1) load_key(mode, '1, '1, '1, '1);
			else load_key(mode, rand64(), rand64(), rand64(), rand64());
			n = 95 + $urandom_range(0, 20);
			for (int i = 0; i < n; i++)
				send_block(1'($urandom_range(0, 1)), rand64(), rand64(), rx_fast);
		end
		rx_fast = 0;
	endtask

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		errors = 0;
		blocks_sent = 0;
		blocks_checked = 0;
		hold_off = 0;
		rx_fast = 0;
		mode_q = MODE_128;
		for (int i = 0; i < 4; i++) key_q[i] = '0;
		build_sboxes();
		expand_keys();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req.valid = 1'b0;
		req.action = ACT_ENC;
		req.block_hi = '0;
		req.block_lo = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_known_vectors();
		test_bad_index();
		test_backpressure();
		test_random();
		drain();
		$display("%0d blocks checked of %0d sent, all key sizes incl. reserved mode, "
			, blocks_checked, blocks_sent);
		$display("encrypt and decrypt, input stall under long output hold-off");
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
